FILE: sv/recurrence_matrix_power_assert.svh
// Assertion macros for the recurrence matrix power block.
// Used by recurrence_matrix_power.sv; expects clk and rst in scope.
`ifndef RECURRENCE_MATRIX_POWER_ASSERT_SVH
`define RECURRENCE_MATRIX_POWER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rmp_pkg.sv
// Package for the recurrence matrix power block: widths, types, microcode.
// No dependencies; used by rmp_ifs.sv and recurrence_matrix_power.sv.
package rmp_pkg;

  localparam int WORD_W  = 32;  // arithmetic wraps modulo 2^WORD_W
  localparam int COEF_W  = 32;
  localparam int INDEX_W = 31;
  localparam int OUT_W   = 32;
  localparam int REG_W   = 2;   // configuration register index
  localparam int PC_W    = 4;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COEF_W-1:0]  coef_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [OUT_W-1:0]   out_t;
  typedef logic [REG_W-1:0]   reg_idx_t;
  typedef logic [PC_W-1:0]    pc_t;
  typedef logic [1:0]         rc_t;    // matrix row or column
  typedef logic [3:0]         ent_t;   // flat 3x3 entry index

  // Configuration register indexes
  localparam reg_idx_t REG_COEF_A = 2'd0;
  localparam reg_idx_t REG_COEF_B = 2'd1;
  localparam reg_idx_t REG_COEF_C = 2'd2;

  // Datapath operations of one microcode step
  typedef enum logic [3:0] {
    OP_WAIT,    // take a word from the request channel
    OP_LOAD,    // set up base, accumulator and exponent
    OP_NOP,     // branch only
    OP_MULAB,   // product = acc * base
    OP_COPYA,   // acc = product
    OP_MULBB,   // product = base * base
    OP_COPYB,   // base = product
    OP_SHIFT,   // exponent >>= 1
    OP_FINISH   // form the term and hand it to the response register
  } op_t;

  // Branch conditions
  typedef enum logic [1:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_EXP_ZERO,
    CND_BIT_CLR
  } cnd_t;

  typedef struct packed {
    op_t  op;
    cnd_t cnd;
    pc_t  target;
  } uword_t;

  // Program addresses
  localparam pc_t PC_WAIT   = 4'd0;
  localparam pc_t PC_LOAD   = 4'd1;
  localparam pc_t PC_TEST   = 4'd2;
  localparam pc_t PC_BIT    = 4'd3;
  localparam pc_t PC_MULAB  = 4'd4;
  localparam pc_t PC_COPYA  = 4'd5;
  localparam pc_t PC_SQUARE = 4'd6;
  localparam pc_t PC_COPYB  = 4'd7;
  localparam pc_t PC_SHIFT  = 4'd8;
  localparam pc_t PC_FINISH = 4'd9;
  localparam pc_t PC_LAST   = PC_FINISH;

  // Control store: square-and-multiply over the exponent bits
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      PC_WAIT:   w = '{op: OP_WAIT,   cnd: CND_NEXT,     target: PC_WAIT};
      PC_LOAD:   w = '{op: OP_LOAD,   cnd: CND_NEXT,     target: PC_WAIT};
      PC_TEST:   w = '{op: OP_NOP,    cnd: CND_EXP_ZERO, target: PC_FINISH};
      PC_BIT:    w = '{op: OP_NOP,    cnd: CND_BIT_CLR,  target: PC_SQUARE};
      PC_MULAB:  w = '{op: OP_MULAB,  cnd: CND_NEXT,     target: PC_WAIT};
      PC_COPYA:  w = '{op: OP_COPYA,  cnd: CND_NEXT,     target: PC_WAIT};
      PC_SQUARE: w = '{op: OP_MULBB,  cnd: CND_NEXT,     target: PC_WAIT};
      PC_COPYB:  w = '{op: OP_COPYB,  cnd: CND_NEXT,     target: PC_WAIT};
      PC_SHIFT:  w = '{op: OP_SHIFT,  cnd: CND_ALWAYS,   target: PC_TEST};
      PC_FINISH: w = '{op: OP_FINISH, cnd: CND_ALWAYS,   target: PC_WAIT};
      default:   w = '{op: OP_NOP,    cnd: CND_ALWAYS,   target: PC_WAIT};
    endcase
    return w;
  endfunction

  // Flat index of entry (r, c) in a row-major 3x3 matrix
  function automatic ent_t ent(input rc_t r, input rc_t c);
    return {2'b00, r} + {1'b0, r, 1'b0} + {2'b00, c};
  endfunction

endpackage

FILE: sv/rmp_ifs.sv
// Channel interfaces of the recurrence matrix power block.
// Depends on rmp_pkg for payload types.
interface rmp_req_if;
  logic            valid;
  logic            ready;
  rmp_pkg::index_t term_index;
  modport source (output valid, output term_index, input ready);
  modport sink   (input valid, input term_index, output ready);
endinterface

interface rmp_rsp_if;
  logic          valid;
  logic          ready;
  rmp_pkg::out_t term_value;
  modport source (output valid, output term_value, input ready);
  modport sink   (input valid, input term_value, output ready);
endinterface

interface rmp_cfg_if;
  logic              valid;
  logic              ready;
  rmp_pkg::reg_idx_t index;
  rmp_pkg::coef_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/recurrence_matrix_power.sv
// Top level of the recurrence matrix power block: microcoded sequencer and datapath.
// Depends on rmp_pkg, rmp_ifs.sv and recurrence_matrix_power_assert.svh.
`include "recurrence_matrix_power_assert.svh"

// Returns F(n) of F(n) = a*F(n-1) + b*F(n-2) + c*F(n-3), F(0)=0, F(1)=F(2)=1,
// modulo 2^32, with a, b, c in configuration registers 0..2 (reset 1). One
// request word is taken at a time; a response is held in an output register, so
// the next request is taken while the previous term waits to be read. The
// companion matrix is raised to n-2 by square-and-multiply, driven by a ten-step
// control store. Each 3x3 product runs through a single 32x32 multiplier and
// adder, one multiply-accumulate per cycle. Configuration writes are always
// accepted and must only come while no request is in flight.
module recurrence_matrix_power (
  input logic     clk,
  input logic     rst,
  rmp_cfg_if.sink cfg,
  rmp_req_if.sink req,
  rmp_rsp_if.source rsp
);

  // Configuration registers
  rmp_pkg::coef_t coef_a;
  rmp_pkg::coef_t coef_b;
  rmp_pkg::coef_t coef_c;

  // Sequencer
  rmp_pkg::pc_t    pc;
  rmp_pkg::pc_t    pc_next;
  rmp_pkg::uword_t cw;
  logic            step_done;
  logic            take;

  // Datapath registers
  rmp_pkg::index_t n;
  rmp_pkg::index_t expo;
  rmp_pkg::word_t  acc  [9];
  rmp_pkg::word_t  base [9];
  rmp_pkg::word_t  bsh  [9];   // copy of base for the right-hand operand port
  rmp_pkg::word_t  prod_m [9]; // result of the running product

  // Multiply-accumulate pipeline
  rmp_pkg::rc_t   mi, mj, mk;
  rmp_pkg::rc_t   pi, pj, pk;
  logic           pipe_v;
  logic           issued_all;
  rmp_pkg::word_t prod;
  rmp_pkg::word_t psum;
  rmp_pkg::word_t sum;
  rmp_pkg::word_t x_op;
  rmp_pkg::word_t y_op;
  logic           is_mul;
  logic           issue;
  logic           mac_last;
  logic           pipe_last;

  // Response register
  logic          rsp_valid;
  rmp_pkg::out_t rsp_value;

  assign cw = rmp_pkg::ucode(pc);

  assign cfg.ready      = 1'b1;
  assign req.ready      = (cw.op == rmp_pkg::OP_WAIT);
  assign rsp.valid      = rsp_valid;
  assign rsp.term_value = rsp_value;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= rmp_pkg::coef_t'(1);
      coef_b <= rmp_pkg::coef_t'(1);
      coef_c <= rmp_pkg::coef_t'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        rmp_pkg::REG_COEF_A: coef_a <= cfg.data;
        rmp_pkg::REG_COEF_B: coef_b <= cfg.data;
        rmp_pkg::REG_COEF_C: coef_c <= cfg.data;
        default: ;
      endcase
    end
  end

  // Operand selection and accumulate
  assign is_mul    = (cw.op == rmp_pkg::OP_MULAB) || (cw.op == rmp_pkg::OP_MULBB);
  assign issue     = is_mul && !issued_all;
  assign mac_last  = (mi == 2'd2) && (mj == 2'd2) && (mk == 2'd2);
  assign pipe_last = pipe_v && (pi == 2'd2) && (pj == 2'd2) && (pk == 2'd2);
  assign x_op = (cw.op == rmp_pkg::OP_MULAB) ? acc[rmp_pkg::ent(mi, mk)]
                                             : base[rmp_pkg::ent(mi, mk)];
  assign y_op = bsh[rmp_pkg::ent(mk, mj)];
  assign sum  = ((pk == 2'd0) ? '0 : psum) + prod;

  // Step completion and branch decision
  always_comb begin
    case (cw.op)
      rmp_pkg::OP_WAIT:   step_done = req.valid;
      rmp_pkg::OP_MULAB,
      rmp_pkg::OP_MULBB:  step_done = pipe_last;
      rmp_pkg::OP_FINISH: step_done = !rsp_valid || rsp.ready;
      default:            step_done = 1'b1;
    endcase
    case (cw.cnd)
      rmp_pkg::CND_ALWAYS:   take = 1'b1;
      rmp_pkg::CND_EXP_ZERO: take = (expo == '0);
      rmp_pkg::CND_BIT_CLR:  take = !expo[0];
      default:               take = 1'b0;
    endcase
    if (!step_done) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + rmp_pkg::pc_t'(1);
    end
  end

  // Advance the sequencer, the MAC counters and the response handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= rmp_pkg::PC_WAIT;
      mi         <= '0;
      mj         <= '0;
      mk         <= '0;
      pipe_v     <= 1'b0;
      issued_all <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      pc     <= pc_next;
      pipe_v <= issue;
      if (issue) begin
        if (mac_last) begin
          issued_all <= 1'b1;
        end
        if (mk == 2'd2) begin
          mk <= '0;
          if (mj == 2'd2) begin
            mj <= '0;
            mi <= (mi == 2'd2) ? '0 : mi + 2'd1;
          end else begin
            mj <= mj + 2'd1;
          end
        end else begin
          mk <= mk + 2'd1;
        end
      end else if (pipe_last) begin
        issued_all <= 1'b0;
      end
      if (cw.op == rmp_pkg::OP_FINISH && step_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath: load, multiply-accumulate, copy, shift, finish
  always_ff @(posedge clk) begin
    if (issue) begin
      prod <= rmp_pkg::word_t'(x_op * y_op);
      pi   <= mi;
      pj   <= mj;
      pk   <= mk;
    end
    if (pipe_v) begin
      psum <= sum;
      if (pk == 2'd2) begin
        prod_m[rmp_pkg::ent(pi, pj)] <= sum;
      end
    end
    case (cw.op)
      rmp_pkg::OP_WAIT: begin
        if (req.valid) begin
          n <= req.term_index;
        end
      end
      rmp_pkg::OP_LOAD: begin
        // Companion matrix in base and its operand copy
        base[0] <= rmp_pkg::word_t'(coef_a);
        base[1] <= rmp_pkg::word_t'(coef_b);
        base[2] <= rmp_pkg::word_t'(coef_c);
        base[3] <= rmp_pkg::word_t'(1);
        base[4] <= '0;
        base[5] <= '0;
        base[6] <= '0;
        base[7] <= rmp_pkg::word_t'(1);
        base[8] <= '0;
        bsh[0]  <= rmp_pkg::word_t'(coef_a);
        bsh[1]  <= rmp_pkg::word_t'(coef_b);
        bsh[2]  <= rmp_pkg::word_t'(coef_c);
        bsh[3]  <= rmp_pkg::word_t'(1);
        bsh[4]  <= '0;
        bsh[5]  <= '0;
        bsh[6]  <= '0;
        bsh[7]  <= rmp_pkg::word_t'(1);
        bsh[8]  <= '0;
        // Zero index leaves acc at zero; indexes one and two keep identity
        acc[0]  <= (n != '0) ? rmp_pkg::word_t'(1) : '0;
        acc[1]  <= '0;
        acc[2]  <= '0;
        acc[3]  <= '0;
        acc[4]  <= (n != '0) ? rmp_pkg::word_t'(1) : '0;
        acc[5]  <= '0;
        acc[6]  <= '0;
        acc[7]  <= '0;
        acc[8]  <= (n != '0) ? rmp_pkg::word_t'(1) : '0;
        expo <= (n >= rmp_pkg::index_t'(3)) ? n - rmp_pkg::index_t'(2) : '0;
      end
      rmp_pkg::OP_COPYA: begin
        for (int e = 0; e < 9; e++) begin
          acc[e] <= prod_m[e];
        end
      end
      rmp_pkg::OP_COPYB: begin
        for (int e = 0; e < 9; e++) begin
          base[e] <= prod_m[e];
          bsh[e]  <= prod_m[e];
        end
      end
      rmp_pkg::OP_SHIFT: begin
        expo <= expo >> 1;
      end
      rmp_pkg::OP_FINISH: begin
        if (step_done) begin
          rsp_value <= rmp_pkg::out_t'(acc[0] + acc[1]);
        end
      end
      default: ;
    endcase
  end

  // Checks
  `RMP_ASSERT_SAME(a_pc_range, 1'b1, pc <= rmp_pkg::PC_LAST, "sequencer left the program")
  `RMP_ASSERT_SAME(a_finish_exp_zero, cw.op == rmp_pkg::OP_FINISH, expo == '0, "finish with exponent bits left")
  `RMP_ASSERT_SAME(a_mac_in_mul, pipe_v || issued_all, is_mul, "MAC pipeline busy outside a product step")
  `RMP_ASSERT_NEXT(a_rsp_from_finish, cw.op == rmp_pkg::OP_FINISH && step_done, rsp_valid && pc == rmp_pkg::PC_WAIT, "finish did not post a response")

endmodule
